[hw/rtl/parallel_nor_flash_command_sequencer_unit_macros.svh]
// Assertion macros used by the flash command sequencer top module.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef PARALLEL_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define PARALLEL_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNFCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pnfcs_pkg.sv]
// Shared types, codes and bus-cycle sequence tables for the flash command sequencer.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package pnfcs_pkg;

  localparam int AddrBits  = 20;
  localparam int DataBits  = 16;
  localparam int LimitBits = 28;
  localparam int Dq6Bit    = 6;

  localparam logic [LimitBits-1:0] PollLimitReset = 28'h0FFF_FFFF;

  // Request codes of the input channel.
  localparam logic [2:0] CMD_READ         = 3'd0;
  localparam logic [2:0] CMD_PROGRAM      = 3'd1;
  localparam logic [2:0] CMD_ERASE_SECTOR = 3'd2;
  localparam logic [2:0] CMD_ERASE_BLOCK  = 3'd3;
  localparam logic [2:0] CMD_ERASE_CHIP   = 3'd4;
  localparam logic [2:0] CMD_READ_DATA    = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // JEDEC unlock addresses and data words, and the command bytes.
  localparam logic [AddrBits-1:0] UNLOCK_ADDR_1 = 20'h00555;
  localparam logic [AddrBits-1:0] UNLOCK_ADDR_2 = 20'h002AA;
  localparam logic [DataBits-1:0] UNLOCK_DATA_1 = 16'h00AA;
  localparam logic [DataBits-1:0] UNLOCK_DATA_2 = 16'h0055;
  localparam logic [DataBits-1:0] CMD_BYTE_PROG = 16'h00A0;
  localparam logic [DataBits-1:0] CMD_BYTE_ERAS = 16'h0080;
  localparam logic [DataBits-1:0] CMD_BYTE_SECT = 16'h0050;
  localparam logic [DataBits-1:0] CMD_BYTE_BLCK = 16'h0030;
  localparam logic [DataBits-1:0] CMD_BYTE_CHIP = 16'h0010;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_READ  = 4'b0010,
    PH_FIRST = 4'b0100,
    PH_POLL  = 4'b1000
  } phase_t;

  // Kind of result run that one accepted item causes.
  typedef enum logic [1:0] {
    RUN_READ_REQ = 2'd0,
    RUN_FINISH   = 2'd1,
    RUN_PROGRAM  = 2'd2,
    RUN_ERASE    = 2'd3
  } run_op_t;

  typedef struct packed {
    run_op_t             op;
    logic [AddrBits-1:0] addr;
    logic [DataBits-1:0] value;
    logic                success;
  } run_desc_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [AddrBits-1:0] addr;
    logic [DataBits-1:0] value;
    logic                success;
  } out_item_t;

  typedef struct packed {
    phase_t               phase;
    logic [LimitBits-1:0] poll_count;
    logic [LimitBits-1:0] poll_limit;
  } ctrl_status_t;

  // Index of the last result in a run.
  function automatic logic [2:0] run_last_idx(input run_op_t op);
    logic [2:0] res;
    case (op)
      RUN_PROGRAM: res = 3'd4;
      RUN_ERASE:   res = 3'd6;
      default:     res = 3'd0;
    endcase
    return res;
  endfunction

  // Result number idx of a run.
  function automatic out_item_t run_item(input run_desc_t d, input logic [2:0] idx);
    out_item_t r;
    r.kind    = KIND_WRITE;
    r.addr    = UNLOCK_ADDR_1;
    r.value   = UNLOCK_DATA_1;
    r.success = 1'b0;
    case (d.op)
      RUN_READ_REQ: begin
        r.kind  = KIND_READ;
        r.addr  = d.addr;
        r.value = '0;
      end
      RUN_FINISH: begin
        r.kind    = KIND_FINISH;
        r.addr    = d.addr;
        r.value   = d.value;
        r.success = d.success;
      end
      RUN_PROGRAM: begin
        case (idx)
          3'd1: begin
            r.addr  = UNLOCK_ADDR_2;
            r.value = UNLOCK_DATA_2;
          end
          3'd2: r.value = CMD_BYTE_PROG;
          3'd3: begin
            r.addr  = d.addr;
            r.value = d.value;
          end
          3'd4: begin
            r.kind  = KIND_READ;
            r.addr  = d.addr;
            r.value = '0;
          end
          default: ;
        endcase
      end
      default: begin
        case (idx) inside
          3'd1, 3'd4: begin
            r.addr  = UNLOCK_ADDR_2;
            r.value = UNLOCK_DATA_2;
          end
          3'd2: r.value = CMD_BYTE_ERAS;
          3'd5: begin
            r.addr  = d.addr;
            r.value = d.value;
          end
          3'd6: begin
            r.kind  = KIND_READ;
            r.addr  = d.addr;
            r.value = '0;
          end
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pnfcs_in_if.sv]
// Request channel of the flash command sequencer: valid, ready and the request payload.
// Depends on pnfcs_pkg for field widths.
`default_nettype none

interface pnfcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     command;
  logic [pnfcs_pkg::AddrBits-1:0] target_address;
  logic [pnfcs_pkg::DataBits-1:0] program_value;
  logic [pnfcs_pkg::DataBits-1:0] returned_word;

  modport source (output valid, command, target_address, program_value, returned_word,
                  input ready);
  modport sink (input valid, command, target_address, program_value, returned_word,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/pnfcs_out_if.sv]
// Result channel of the flash command sequencer: valid, ready and one bus cycle or finish.
// Depends on pnfcs_pkg for field widths.
`default_nettype none

interface pnfcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [pnfcs_pkg::AddrBits-1:0] bus_address;
  logic [pnfcs_pkg::DataBits-1:0] bus_value;
  logic                           success;
  logic                           last_of_run;

  modport source (output valid, kind, bus_address, bus_value, success, last_of_run,
                  input ready);
  modport sink (input valid, kind, bus_address, bus_value, success, last_of_run,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/parallel_nor_flash_command_sequencer_unit.sv]
// A request's first result passes from the run register into the output register.
// A read request, a poll step or a finish gives one result, a word program five and
// an erase seven, one result per cycle while the result channel does not stall.
// Input transfers that cause no result are also taken only while the emitter can accept.
// Reset (rst_n low, synchronous) returns to idle, clears the operation state and
// loads the poll limit with its maximum; the channels come up empty.
`default_nettype none

`include "parallel_nor_flash_command_sequencer_unit_macros.svh"

module parallel_nor_flash_command_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pnfcs_in_if.sink                             in_ch,
  pnfcs_out_if.source                          out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [pnfcs_pkg::LimitBits-1:0] cfg_wdata
);

  // An input transfer is decoded in the same cycle it is taken: the operation
  // state updates at that edge and the run of results it causes is captured in
  // the run register of the emitter. The emitter walks that run one bus cycle at
  // a time into the output register, so the next request or read-data transfer
  // is taken in the same cycle the last result of the current run moves out.
  logic                     in_fire;
  logic                     run_load;
  pnfcs_pkg::run_desc_t     run_desc;
  pnfcs_pkg::ctrl_status_t  status;
  pnfcs_pkg::out_item_t     out_item;
  logic                     emit_in_ready;
  logic                     emit_out_valid;
  logic                     emit_out_last;

  assign in_fire     = in_ch.valid && emit_in_ready;
  assign in_ch.ready = emit_in_ready;

  pnfcs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .command        (in_ch.command),
    .target_address (in_ch.target_address),
    .program_value  (in_ch.program_value),
    .returned_word  (in_ch.returned_word),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .run_load       (run_load),
    .run_desc       (run_desc),
    .status         (status)
  );

  pnfcs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_load  (run_load),
    .run_desc  (run_desc),
    .in_ready  (emit_in_ready),
    .out_valid (emit_out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item),
    .out_last  (emit_out_last)
  );

  // The result channel is driven straight from the output register.
  assign out_ch.valid       = emit_out_valid;
  assign out_ch.kind        = out_item.kind;
  assign out_ch.bus_address = out_item.addr;
  assign out_ch.bus_value   = out_item.value;
  assign out_ch.success     = out_item.success;
  assign out_ch.last_of_run = emit_out_last;

  // A request taken while idle always starts an operation.
  `PNFCS_ASSERT_NEXT(a_req_starts_op,
    in_fire && status.phase == pnfcs_pkg::PH_IDLE && (in_ch.command == pnfcs_pkg::CMD_READ ||
    in_ch.command == pnfcs_pkg::CMD_PROGRAM || in_ch.command == pnfcs_pkg::CMD_ERASE_SECTOR ||
    in_ch.command == pnfcs_pkg::CMD_ERASE_BLOCK || in_ch.command == pnfcs_pkg::CMD_ERASE_CHIP),
    status.phase != pnfcs_pkg::PH_IDLE, "request taken while idle did not start an operation")
  // A finish always closes the run of its transfer.
  `PNFCS_ASSERT_SAME(a_finish_is_last,
    emit_out_valid && out_item.kind == pnfcs_pkg::KIND_FINISH, emit_out_last,
    "finish result not marked last of run")
  // Only a finish carries a success flag.
  `PNFCS_ASSERT_SAME(a_success_on_finish_only,
    emit_out_valid && out_item.kind != pnfcs_pkg::KIND_FINISH, !out_item.success,
    "success flag set on a bus cycle")
  // While polling, the compare count stays below the limit.
  `PNFCS_ASSERT_SAME(a_poll_count_bound, status.phase == pnfcs_pkg::PH_POLL,
    status.poll_count < status.poll_limit, "poll count reached the limit while polling")

endmodule

`default_nettype wire

[hw/rtl/pnfcs_ctrl.sv]
// Operation state and request decode: turns each accepted transfer that is not ignored into a run descriptor.
// Depends on pnfcs_pkg.
`default_nettype none

module pnfcs_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_fire,
  input  wire logic [2:0]                      command,
  input  wire logic [pnfcs_pkg::AddrBits-1:0]  target_address,
  input  wire logic [pnfcs_pkg::DataBits-1:0]  program_value,
  input  wire logic [pnfcs_pkg::DataBits-1:0]  returned_word,
  input  wire logic                            cfg_we,
  input  wire logic [pnfcs_pkg::LimitBits-1:0] cfg_wdata,
  output logic                                 run_load,
  output pnfcs_pkg::run_desc_t                 run_desc,
  output pnfcs_pkg::ctrl_status_t              status
);

  pnfcs_pkg::phase_t               phase_r, phase_nxt;
  logic [pnfcs_pkg::AddrBits-1:0]  op_addr_r, op_addr_nxt;
  logic                            prev_tog_r, prev_tog_nxt;
  logic [pnfcs_pkg::LimitBits-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [pnfcs_pkg::LimitBits-1:0] poll_limit_r;
  logic [pnfcs_pkg::LimitBits-1:0] cnt_inc;
  logic                            tog;

  assign tog     = returned_word[pnfcs_pkg::Dq6Bit];
  assign cnt_inc = poll_cnt_r + 1'b1;

  always_comb begin
    phase_nxt        = phase_r;
    op_addr_nxt      = op_addr_r;
    prev_tog_nxt     = prev_tog_r;
    poll_cnt_nxt     = poll_cnt_r;
    run_load         = 1'b0;
    run_desc.op      = pnfcs_pkg::RUN_FINISH;
    run_desc.addr    = op_addr_r;
    run_desc.value   = '0;
    run_desc.success = 1'b0;
    if (in_fire) begin
      unique case (command) inside
        pnfcs_pkg::CMD_READ: begin
          if (phase_r == pnfcs_pkg::PH_IDLE) begin
            run_load      = 1'b1;
            run_desc.op   = pnfcs_pkg::RUN_READ_REQ;
            run_desc.addr = target_address;
            op_addr_nxt   = target_address;
            phase_nxt     = pnfcs_pkg::PH_READ;
          end
        end
        pnfcs_pkg::CMD_PROGRAM: begin
          if (phase_r == pnfcs_pkg::PH_IDLE) begin
            run_load       = 1'b1;
            run_desc.op    = pnfcs_pkg::RUN_PROGRAM;
            run_desc.addr  = target_address;
            run_desc.value = program_value;
            op_addr_nxt    = target_address;
            phase_nxt      = pnfcs_pkg::PH_FIRST;
          end
        end
        pnfcs_pkg::CMD_ERASE_SECTOR, pnfcs_pkg::CMD_ERASE_BLOCK,
        pnfcs_pkg::CMD_ERASE_CHIP: begin
          if (phase_r == pnfcs_pkg::PH_IDLE) begin
            run_load    = 1'b1;
            run_desc.op = pnfcs_pkg::RUN_ERASE;
            phase_nxt   = pnfcs_pkg::PH_FIRST;
            if (command == pnfcs_pkg::CMD_ERASE_CHIP) begin
              // Chip erase ignores the address and polls the unlock address.
              run_desc.addr  = pnfcs_pkg::UNLOCK_ADDR_1;
              run_desc.value = pnfcs_pkg::CMD_BYTE_CHIP;
            end else begin
              run_desc.addr  = target_address;
              run_desc.value = (command == pnfcs_pkg::CMD_ERASE_SECTOR) ?
                               pnfcs_pkg::CMD_BYTE_SECT : pnfcs_pkg::CMD_BYTE_BLCK;
            end
            op_addr_nxt = run_desc.addr;
          end
        end
        pnfcs_pkg::CMD_READ_DATA: begin
          unique case (phase_r)
            pnfcs_pkg::PH_READ: begin
              run_load         = 1'b1;
              run_desc.value   = returned_word;
              run_desc.success = 1'b1;
              phase_nxt        = pnfcs_pkg::PH_IDLE;
            end
            pnfcs_pkg::PH_FIRST: begin
              run_load     = 1'b1;
              prev_tog_nxt = tog;
              poll_cnt_nxt = '0;
              if (poll_limit_r == '0) begin
                phase_nxt = pnfcs_pkg::PH_IDLE;
              end else begin
                run_desc.op = pnfcs_pkg::RUN_READ_REQ;
                phase_nxt   = pnfcs_pkg::PH_POLL;
              end
            end
            pnfcs_pkg::PH_POLL: begin
              run_load = 1'b1;
              if (tog == prev_tog_r) begin
                run_desc.success = 1'b1;
                phase_nxt        = pnfcs_pkg::PH_IDLE;
              end else begin
                prev_tog_nxt = tog;
                poll_cnt_nxt = cnt_inc;
                if (cnt_inc >= poll_limit_r) begin
                  phase_nxt = pnfcs_pkg::PH_IDLE;
                end else begin
                  run_desc.op = pnfcs_pkg::RUN_READ_REQ;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pnfcs_pkg::PH_IDLE;
      op_addr_r    <= '0;
      prev_tog_r   <= 1'b0;
      poll_cnt_r   <= '0;
      poll_limit_r <= pnfcs_pkg::PollLimitReset;
    end else begin
      phase_r    <= phase_nxt;
      op_addr_r  <= op_addr_nxt;
      prev_tog_r <= prev_tog_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      if (cfg_we) begin
        poll_limit_r <= cfg_wdata;
      end
    end
  end

  assign status.phase      = phase_r;
  assign status.poll_count = poll_cnt_r;
  assign status.poll_limit = poll_limit_r;

endmodule

`default_nettype wire

[hw/rtl/pnfcs_emit.sv]
// Run register and output register: expands one run descriptor into its bus cycles.
// Depends on pnfcs_pkg for the sequence tables.
`default_nettype none

module pnfcs_emit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 run_load,
  input  wire pnfcs_pkg::run_desc_t run_desc,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pnfcs_pkg::out_item_t      out_item,
  output logic                      out_last
);

  logic                 busy_r, busy_nxt;
  logic [2:0]           idx_r, idx_nxt;
  pnfcs_pkg::run_desc_t desc_r;
  logic                 out_valid_r, out_valid_nxt;
  pnfcs_pkg::out_item_t out_item_r;
  logic                 out_last_r;
  logic                 adv;
  logic                 at_last;

  // A result moves into the output register when it is empty or being drained.
  assign adv      = busy_r && (!out_valid_r || out_ready);
  assign at_last  = (idx_r == pnfcs_pkg::run_last_idx(desc_r.op));
  assign in_ready = !busy_r || (adv && at_last);

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 3'd1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (run_load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_load) begin
      desc_r <= run_desc;
    end
    if (adv) begin
      out_item_r <= pnfcs_pkg::run_item(desc_r, idx_r);
      out_last_r <= at_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the parallel NOR flash command sequencer.
// Depends on pnfcs_pkg, the pnfcs_in_if / pnfcs_out_if channel interfaces and the RTL top.
// A scoreboard class predicts every bus cycle and finish, and checks each output transfer.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pnfcs_pkg::*;

  // The command field is three bits wide, so two codes carry no meaning at all.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam int CycleLimit      = 400000;
  localparam int ItemsPerSetting = 58;
  localparam int Settings        = 6;

  // One output transfer: a bus write, a bus read request or an operation finish.
  typedef struct packed {
    logic [1:0]          kind;
    logic [AddrBits-1:0] addr;
    logic [DataBits-1:0] value;
    logic                success;
    logic                last;
  } bus_cycle_t;

  // Tracks the sequencer's operation state and the bus cycles still owed by the block.
  class flash_bus_scoreboard;
    phase_t               phase;
    logic [AddrBits-1:0]  op_addr;
    logic                 prev_dq6;
    logic [LimitBits-1:0] polls;
    logic [LimitBits-1:0] poll_limit;
    bus_cycle_t           expected_cycles[$];
    int                   mismatches;

    function new();
      phase      = PH_IDLE;
      op_addr    = '0;
      prev_dq6   = 1'b0;
      polls      = '0;
      poll_limit = PollLimitReset;
      mismatches = 0;
    endfunction

    function void set_poll_limit(input logic [LimitBits-1:0] value);
      poll_limit = value;
    endfunction

    function void add_cycle(input logic [1:0] kind, input logic [AddrBits-1:0] addr,
                            input logic [DataBits-1:0] value, input logic ok);
      bus_cycle_t c;
      c.kind    = kind;
      c.addr    = addr;
      c.value   = value;
      c.success = ok;
      c.last    = 1'b0;
      expected_cycles.push_back(c);
    endfunction

    // Works out the bus cycles that one accepted input transfer causes and returns
    // how many there are. Ignored transfers leave the state alone and return zero.
    function int note_request(input logic [2:0] cmd, input logic [AddrBits-1:0] addr,
                              input logic [DataBits-1:0] pval,
                              input logic [DataBits-1:0] rword);
      int                  queued;
      logic                dq6;
      logic [DataBits-1:0] erase_code;
      bus_cycle_t          tail;
      queued = expected_cycles.size();
      dq6    = rword[Dq6Bit];
      if (cmd <= CMD_ERASE_CHIP) begin
        if (phase == PH_IDLE) begin
          if (cmd == CMD_READ) begin
            op_addr = addr;
            add_cycle(KIND_READ, addr, '0, 1'b0);
            phase = PH_READ;
          end else begin
            add_cycle(KIND_WRITE, UNLOCK_ADDR_1, UNLOCK_DATA_1, 1'b0);
            add_cycle(KIND_WRITE, UNLOCK_ADDR_2, UNLOCK_DATA_2, 1'b0);
            if (cmd == CMD_PROGRAM) begin
              add_cycle(KIND_WRITE, UNLOCK_ADDR_1, CMD_BYTE_PROG, 1'b0);
              add_cycle(KIND_WRITE, addr, pval, 1'b0);
            end else begin
              // Erase setup byte, then a second unlock pair before the erase code.
              add_cycle(KIND_WRITE, UNLOCK_ADDR_1, CMD_BYTE_ERAS, 1'b0);
              add_cycle(KIND_WRITE, UNLOCK_ADDR_1, UNLOCK_DATA_1, 1'b0);
              add_cycle(KIND_WRITE, UNLOCK_ADDR_2, UNLOCK_DATA_2, 1'b0);
              case (cmd)
                CMD_ERASE_SECTOR: erase_code = CMD_BYTE_SECT;
                CMD_ERASE_BLOCK:  erase_code = CMD_BYTE_BLCK;
                default: begin
                  // A chip erase ignores the target and works at the unlock address.
                  erase_code = CMD_BYTE_CHIP;
                  addr       = UNLOCK_ADDR_1;
                end
              endcase
              add_cycle(KIND_WRITE, addr, erase_code, 1'b0);
            end
            op_addr = addr;
            add_cycle(KIND_READ, addr, '0, 1'b0);
            phase = PH_FIRST;
          end
        end
      end else if (cmd == CMD_READ_DATA) begin
        case (phase)
          PH_READ: begin
            add_cycle(KIND_FINISH, op_addr, rword, 1'b1);
            phase = PH_IDLE;
          end
          PH_FIRST: begin
            prev_dq6 = dq6;
            polls    = '0;
            if (poll_limit == '0) begin
              add_cycle(KIND_FINISH, op_addr, '0, 1'b0);
              phase = PH_IDLE;
            end else begin
              add_cycle(KIND_READ, op_addr, '0, 1'b0);
              phase = PH_POLL;
            end
          end
          PH_POLL: begin
            if (dq6 == prev_dq6) begin
              add_cycle(KIND_FINISH, op_addr, '0, 1'b1);
              phase = PH_IDLE;
            end else begin
              prev_dq6 = dq6;
              polls    = polls + 1'b1;
              if (polls >= poll_limit) begin
                add_cycle(KIND_FINISH, op_addr, '0, 1'b0);
                phase = PH_IDLE;
              end else begin
                add_cycle(KIND_READ, op_addr, '0, 1'b0);
              end
            end
          end
          default: ;
        endcase
      end
      if (expected_cycles.size() > queued) begin
        tail      = expected_cycles.pop_back();
        tail.last = 1'b1;
        expected_cycles.push_back(tail);
      end
      return expected_cycles.size() - queued;
    endfunction

    function void check_bus_cycle(input bus_cycle_t got);
      bus_cycle_t want;
      if (expected_cycles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: kind %0d addr %05h value %04h ok %0b last %0b",
                   got.kind, got.addr, got.value, got.success, got.last);
      end else begin
        want = expected_cycles.pop_front();
        if (got.kind !== want.kind || got.addr !== want.addr || got.value !== want.value ||
            got.success !== want.success || got.last !== want.last) begin
          mismatches++;
          // Fields in order: kind, address, value, success, last of run.
          if (mismatches <= 10)
            $display("mismatch: want %0d/%05h/%04h/%0b/%0b got %0d/%05h/%04h/%0b/%0b",
                     want.kind, want.addr, want.value, want.success, want.last,
                     got.kind, got.addr, got.value, got.success, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [LimitBits-1:0] cfg_wdata;

  pnfcs_in_if  in_ch();
  pnfcs_out_if out_ch();

  // When steady is set, neither side of the block idles or stalls.
  bit                  steady;
  int                  sent_items;
  int                  cycles;
  flash_bus_scoreboard sb;

  parallel_nor_flash_command_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that hangs on a missing transfer ends here as a failure.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[parallel_nor_flash_command_sequencer_unit] ERROR");
    $finish;
  end

  // The result side stalls about a third of the time, except during the steady stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Every output transfer is checked at the rising edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_bus_cycle({out_ch.kind, out_ch.bus_address, out_ch.bus_value,
                          out_ch.success, out_ch.last_of_run});
  end

  // Presents one input item, starting at a falling edge, and returns at the falling edge
  // after its transfer. Valid stays high on return so that a following item can go out
  // back to back; whoever stops sending lowers it.
  task automatic send_item(input logic [2:0] cmd, input logic [AddrBits-1:0] addr,
                           input logic [DataBits-1:0] pval,
                           input logic [DataBits-1:0] rword);
    while (!steady && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.target_address <= addr;
    in_ch.program_value  <= pval;
    in_ch.returned_word  <= rword;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(sb.note_request(cmd, addr, pval, rword));
    sent_items++;
    @(negedge clk);
  endtask

  // A random flash status word with DQ6 forced to the given level.
  function automatic logic [DataBits-1:0] word_with_dq6(input logic dq6);
    logic [DataBits-1:0] w;
    w         = DataBits'($urandom);
    w[Dq6Bit] = dq6;
    return w;
  endfunction

  // Now and then, a request that the busy block must drop, or a meaningless code.
  task automatic maybe_busy_request();
    logic [2:0] cmd;
    if ($urandom_range(99) < 15) begin
      cmd = 3'($urandom_range(7));
      if (cmd == CMD_READ_DATA)
        cmd = CMD_UNUSED_HI;
      send_item(cmd, AddrBits'($urandom), DataBits'($urandom), DataBits'($urandom));
    end
  endtask

  // Items that the idle block ignores: stray read data and the unused codes.
  task automatic stray_item();
    logic [2:0] cmd;
    case ($urandom_range(2))
      0:       cmd = CMD_READ_DATA;
      1:       cmd = CMD_UNUSED_LO;
      default: cmd = CMD_UNUSED_HI;
    endcase
    send_item(cmd, AddrBits'($urandom), DataBits'($urandom), DataBits'($urandom));
  endtask

  // One complete operation with random content. For writes and erases the flash model
  // lets DQ6 toggle a random number of times before it settles, so the poll limit
  // decides whether the operation ends in success or failure.
  task automatic run_operation();
    logic [2:0] op;
    int         flips;
    int         flip_goal;
    logic       dq6;
    op = 3'($urandom_range(4));
    send_item(op, AddrBits'($urandom), DataBits'($urandom), DataBits'($urandom));
    maybe_busy_request();
    if (op == CMD_READ) begin
      send_item(CMD_READ_DATA, AddrBits'($urandom), DataBits'($urandom),
                DataBits'($urandom));
    end else begin
      send_item(CMD_READ_DATA, AddrBits'($urandom), DataBits'($urandom),
                word_with_dq6(1'($urandom)));
      flips     = 0;
      flip_goal = $urandom_range(4);
      while (sb.phase == PH_POLL) begin
        maybe_busy_request();
        if (flips < flip_goal) begin
          dq6 = ~sb.prev_dq6;
          flips++;
        end else begin
          dq6 = sb.prev_dq6;
        end
        send_item(CMD_READ_DATA, AddrBits'($urandom), DataBits'($urandom),
                  word_with_dq6(dq6));
      end
    end
  endtask

  // Stops sending, waits for every owed output transfer, then lets the pipeline settle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_cycles.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_poll_limit(input logic [LimitBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_poll_limit(value);
  endtask

  initial begin
    logic [LimitBits-1:0] limits [Settings];
    sb                   = new();
    steady               = 1'b0;
    sent_items           = 0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_READ;
    in_ch.target_address <= '0;
    in_ch.program_value  <= '0;
    in_ch.returned_word  <= '0;

    // Zero limit fails at the first poll word; a limit of one fails at the first toggle;
    // the maximum setting runs with no idling on either side.
    limits[0] = '0;
    limits[1] = LimitBits'(1);
    limits[2] = PollLimitReset;
    limits[3] = LimitBits'(3);
    limits[4] = LimitBits'($urandom_range(6, 2));
    limits[5] = LimitBits'(2);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the poll limit still at its reset value.
    // Reads at both ends of the address and data range.
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ_DATA, '0, '0, 16'h0000);
    send_item(CMD_READ, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_READ_DATA, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    // Word program at the top address; a chip erase sent mid-operation is dropped.
    // DQ6 toggles once and then holds low.
    send_item(CMD_PROGRAM, 20'hFFFFF, 16'hFFFF, '0);
    send_item(CMD_ERASE_CHIP, '0, '0, '0);
    send_item(CMD_READ_DATA, '0, '0, 16'h0040);
    send_item(CMD_READ_DATA, '0, '0, 16'h0000);
    send_item(CMD_READ_DATA, '0, '0, 16'hFFBF);
    // Sector erase at address zero, DQ6 steady high.
    send_item(CMD_ERASE_SECTOR, '0, '0, 16'hFFFF);
    send_item(CMD_READ_DATA, '0, '0, 16'hFFFF);
    send_item(CMD_READ_DATA, '0, '0, 16'h0040);
    // Block erase with alternating bit patterns, one toggle before settling.
    send_item(CMD_ERASE_BLOCK, 20'hAAAAA, 16'h5555, '0);
    send_item(CMD_READ_DATA, 20'h55555, 16'hAAAA, 16'h5555);
    send_item(CMD_READ_DATA, 20'h55555, 16'hAAAA, 16'hAAAA);
    send_item(CMD_READ_DATA, 20'h55555, 16'hAAAA, 16'h0000);
    // Chip erase: the target address must not show up anywhere.
    send_item(CMD_ERASE_CHIP, 20'h12345, 16'h1234, '0);
    send_item(CMD_READ_DATA, '0, '0, 16'h0040);
    send_item(CMD_READ_DATA, '0, '0, 16'h0040);
    // Data returned while idle, and the two unused codes, are all ignored.
    send_item(CMD_READ_DATA, 20'h0F0F0, 16'hF0F0, 16'h1234);
    send_item(CMD_UNUSED_LO, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_UNUSED_HI, '0, '0, '0);
    quiesce();

    // Random part: each poll limit setting gets its own batch of whole operations,
    // mixed with a little noise. Every input item counts toward a batch.
    for (int s = 0; s < Settings; s++) begin
      steady = (s == 2);
      write_poll_limit(limits[s]);
      sent_items = 0;
      while (sent_items < ItemsPerSetting) begin
        if ($urandom_range(99) < 12)
          stray_item();
        else
          run_operation();
      end
      quiesce();
    end

    if (sb.mismatches == 0)
      $display("[parallel_nor_flash_command_sequencer_unit] OK");
    else
      $display("[parallel_nor_flash_command_sequencer_unit] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pnfcs_pkg.sv
hw/rtl/pnfcs_in_if.sv
hw/rtl/pnfcs_out_if.sv
hw/rtl/pnfcs_ctrl.sv
hw/rtl/pnfcs_emit.sv
hw/rtl/parallel_nor_flash_command_sequencer_unit.sv
test/testbench.sv
